// ===== src/sgm_pkg.sv =====
// Shared widths, register indexes and job types for the Sobel magnitude core.
`default_nettype none
package sgm_pkg;

   localparam int PIXEL_WIDTH       = 8;
   localparam int MAG_WIDTH         = 11;
   localparam int COORD_WIDTH       = 10;
   localparam int GRAD_WIDTH        = 11;
   localparam int SQ_WIDTH          = 21;
   localparam int CSR_INDEX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH    = 11;
   localparam int DEFAULT_MAX_WIDTH = 1024;
   localparam int HEIGHT_LIMIT      = 1024;
   localparam int QUEUE_DEPTH       = 2;
   localparam int MAG_MAX           = 1442;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam logic [CSR_DATA_WIDTH-1:0] RESET_IMAGE_WIDTH  = 11'd1024;
   localparam logic [CSR_DATA_WIDTH-1:0] RESET_IMAGE_HEIGHT = 11'd1024;

   // one interior pixel handed from front to back
   typedef struct packed {
      logic signed [GRAD_WIDTH-1:0] gx;
      logic signed [GRAD_WIDTH-1:0] gy;
      logic [COORD_WIDTH-1:0]       row;
      logic [COORD_WIDTH-1:0]       col;
      logic                         last;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

// ===== src/sgm_queue.sv =====
// Short FIFO of gradient jobs between the front and back ends.
`default_nettype none
module sgm_queue
   import sgm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire job_type          push_word,
   input  wire logic             pop,
   output job_type               pop_word,
   output queue_status_type      status
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

   job_type            entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [CNTW-1:0]    count_ff;
   logic               do_push, do_pop;

   assign status.full  = (count_ff == CNTW'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_word     = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// ===== src/sgm_front.sv =====
// Front end: pixel intake, line stores, 3x3 window, counters and Sobel gradients.
`default_nettype none
module sgm_front
   import sgm_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic [PIXEL_WIDTH-1:0]      req_pixel,
   input  wire logic                        csr_valid,
   input  wire logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]   csr_data,
   output logic                             job_push,
   output job_type                          job_word,
   input  wire queue_status_type            q_status
);

   localparam int CW = $clog2(MAX_WIDTH);

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type                 state_ff;
   logic [CSR_DATA_WIDTH-1:0] width_ff, height_ff;
   logic [CW-1:0]             col_ff;
   logic [COORD_WIDTH-1:0]    row_ff;
   logic [PIXEL_WIDTH-1:0]    pixel_ff, up_rd_ff, mid_rd_ff;
   logic [PIXEL_WIDTH-1:0]    win_ff [3][3];   // [row top..bottom][col oldest..newest]
   logic [PIXEL_WIDTH-1:0]    upper_mem [MAX_WIDTH];
   logic [PIXEL_WIDTH-1:0]    middle_mem [MAX_WIDTH];
   logic [PIXEL_WIDTH-1:0]    win_in [3][3];
   logic [CW-1:0]             col_last, col_m1;
   logic [COORD_WIDTH-1:0]    row_last;
   logic                      accept, csr_write, interior;
   logic [PIXEL_WIDTH+1:0]    sx_pos, sx_neg, sy_pos, sy_neg;

   assign accept    = req_push && !req_full;
   assign req_full  = (state_ff != ST_IDLE) || q_status.full;
   assign csr_write = csr_valid &&
                      (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT);

   // effective sizes, saturated, as last index
   always_comb begin
      if (width_ff < 11'd3) begin
         col_last = CW'(2);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         col_last = CW'(MAX_WIDTH - 1);
      end else begin
         col_last = CW'(width_ff - 11'd1);
      end
      if (height_ff < 11'd3) begin
         row_last = COORD_WIDTH'(2);
      end else if (32'(height_ff) > HEIGHT_LIMIT) begin
         row_last = COORD_WIDTH'(HEIGHT_LIMIT - 1);
      end else begin
         row_last = COORD_WIDTH'(height_ff - 11'd1);
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r][0] = win_ff[r][1];
         win_in[r][1] = win_ff[r][2];
      end
      win_in[0][2] = up_rd_ff;
      win_in[1][2] = mid_rd_ff;
      win_in[2][2] = pixel_ff;
   end

   always_comb begin
      sx_pos = 10'(win_in[0][2]) + {1'b0, win_in[1][2], 1'b0} + 10'(win_in[2][2]);
      sx_neg = 10'(win_in[0][0]) + {1'b0, win_in[1][0], 1'b0} + 10'(win_in[2][0]);
      sy_pos = 10'(win_in[2][0]) + {1'b0, win_in[2][1], 1'b0} + 10'(win_in[2][2]);
      sy_neg = 10'(win_in[0][0]) + {1'b0, win_in[0][1], 1'b0} + 10'(win_in[0][2]);
   end

   assign interior = (row_ff >= COORD_WIDTH'(2)) && (col_ff >= CW'(2));
   assign col_m1   = col_ff - 1'b1;

   assign job_push      = (state_ff == ST_READ) && interior;
   assign job_word.gx   = $signed({1'b0, sx_pos}) - $signed({1'b0, sx_neg});
   assign job_word.gy   = $signed({1'b0, sy_pos}) - $signed({1'b0, sy_neg});
   assign job_word.row  = row_ff - 1'b1;
   assign job_word.col  = COORD_WIDTH'(col_m1);
   assign job_word.last = (row_ff == row_last) && (col_ff == col_last);

   // line stores: read on accept, write back the same column in the cycle after
   always_ff @(posedge clock) begin
      if (accept) begin
         up_rd_ff  <= upper_mem[col_ff];
         mid_rd_ff <= middle_mem[col_ff];
      end
      if (state_ff == ST_READ) begin
         upper_mem[col_ff]  <= mid_rd_ff;
         middle_mem[col_ff] <= pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pixel_ff <= req_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         width_ff  <= RESET_IMAGE_WIDTH;
         height_ff <= RESET_IMAGE_HEIGHT;
         col_ff    <= '0;
         row_ff    <= '0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_IMAGE_WIDTH) begin
               width_ff <= csr_data;
            end else begin
               height_ff <= csr_data;
            end
            col_ff <= '0;
            row_ff <= '0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_IDLE;
               win_ff   <= win_in;
               // a register write restarts the frame and wins over the advance
               if (!csr_write) begin
                  if (col_ff == col_last) begin
                     col_ff <= '0;
                     row_ff <= (row_ff == row_last) ? '0 : row_ff + 1'b1;
                  end else begin
                     col_ff <= col_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== src/sgm_back.sv =====
// Back end: squares the gradients, bit-serial floor square root, result register.
`default_nettype none
module sgm_back
   import sgm_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   output logic                         job_pop,
   input  wire job_type                 job_word,
   input  wire queue_status_type        q_status,
   output logic                         rsp_empty,
   input  wire logic                    rsp_pop,
   output logic [MAG_WIDTH-1:0]         rsp_magnitude,
   output logic [COORD_WIDTH-1:0]       rsp_out_row,
   output logic [COORD_WIDTH-1:0]       rsp_out_col,
   output logic                         rsp_frame_last
);

   localparam int RADW  = 2 * MAG_WIDTH;
   localparam int REMW  = MAG_WIDTH + 1;
   localparam int STEPW = $clog2(MAG_WIDTH);

   typedef enum logic [1:0] {
      B_IDLE,
      B_SQUARE,
      B_ROOT,
      B_DONE
   } state_type;

   state_type                     state_ff;
   job_type                       job_ff;
   logic [RADW-1:0]               rad_ff;
   logic [REMW-1:0]               rem_ff;
   logic [MAG_WIDTH-1:0]          root_ff;
   logic [STEPW-1:0]              step_ff;
   logic                          out_valid_ff;
   logic [MAG_WIDTH-1:0]          mag_ff;
   logic [COORD_WIDTH-1:0]        row_ff, col_ff;
   logic                          last_ff;
   logic signed [2*GRAD_WIDTH-1:0] gx_sq, gy_sq;
   logic [SQ_WIDTH-1:0]           sq_sum;
   logic [REMW+1:0]               cand, trial;
   logic                          fits;
   logic                          load_out;

   assign job_pop = (state_ff == B_IDLE) && !q_status.empty;

   // each square stays below 2^20
   assign gx_sq  = job_ff.gx * job_ff.gx;
   assign gy_sq  = job_ff.gy * job_ff.gy;
   assign sq_sum = {1'b0, gx_sq[SQ_WIDTH-2:0]} + {1'b0, gy_sq[SQ_WIDTH-2:0]};

   assign cand  = {rem_ff, rad_ff[RADW-1 -: 2]};
   assign trial = {1'b0, root_ff, 2'b01};
   assign fits  = (cand >= trial);

   // finished root moves out when the result register is free or being popped
   assign load_out = (state_ff == B_DONE) && (!out_valid_ff || rsp_pop);

   assign rsp_empty      = !out_valid_ff;
   assign rsp_magnitude  = mag_ff;
   assign rsp_out_row    = row_ff;
   assign rsp_out_col    = col_ff;
   assign rsp_frame_last = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (job_pop) begin
                  job_ff   <= job_word;
                  state_ff <= B_SQUARE;
               end
            end
            B_SQUARE: begin
               rad_ff   <= RADW'(sq_sum);
               rem_ff   <= '0;
               root_ff  <= '0;
               step_ff  <= STEPW'(MAG_WIDTH - 1);
               state_ff <= B_ROOT;
            end
            B_ROOT: begin
               // two radicand bits in, one root bit out
               if (fits) begin
                  rem_ff  <= REMW'(cand - trial);
                  root_ff <= {root_ff[MAG_WIDTH-2:0], 1'b1};
               end else begin
                  rem_ff  <= REMW'(cand);
                  root_ff <= {root_ff[MAG_WIDTH-2:0], 1'b0};
               end
               rad_ff <= {rad_ff[RADW-3:0], 2'b00};
               if (step_ff == '0) begin
                  state_ff <= B_DONE;
               end else begin
                  step_ff <= step_ff - 1'b1;
               end
            end
            B_DONE: begin
               if (load_out) begin
                  mag_ff   <= root_ff;
                  row_ff   <= job_ff.row;
                  col_ff   <= job_ff.col;
                  last_ff  <= job_ff.last;
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== src/sobel_gradient_magnitude_core.sv =====
// Top level of the Sobel gradient magnitude core: front, job queue and back.
//
//   channel  direction  handshake           payload
//   req      in         push / full         req_pixel
//   rsp      out        empty / pop         rsp_magnitude, rsp_out_row, rsp_out_col,
//                                           rsp_frame_last
//   csr      in         csr_valid/csr_ready csr_index, csr_data
//
// Front takes a pixel word with a registered line store read, then a window update. Back
// works on one interior pixel at a time: pop, square, 11 root steps, load; the 11-step
// square root sets the sustained rate for interior pixels while rsp does not stall.
// Synchronous active-high reset clears counters, queue and valids; line stores are not
// cleared. req_full rises while the front is busy or the queue is full; rsp stalls hold
// the back in its final state.
`default_nettype none
module sobel_gradient_magnitude_core
   import sgm_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic [PIXEL_WIDTH-1:0]      req_pixel,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output logic [MAG_WIDTH-1:0]             rsp_magnitude,
   output logic [COORD_WIDTH-1:0]           rsp_out_row,
   output logic [COORD_WIDTH-1:0]           rsp_out_col,
   output logic                             rsp_frame_last,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]   csr_data
);

   logic             job_push, job_pop;
   job_type          push_word, pop_word;
   queue_status_type q_status;

   assign csr_ready = 1'b1;

   sgm_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_pixel (req_pixel),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .job_push  (job_push),
      .job_word  (push_word),
      .q_status  (q_status)
   );

   sgm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_word (push_word),
      .pop       (job_pop),
      .pop_word  (pop_word),
      .status    (q_status)
   );

   sgm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_pop        (job_pop),
      .job_word       (pop_word),
      .q_status       (q_status),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_magnitude  (rsp_magnitude),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_frame_last (rsp_frame_last)
   );

   // a job is never offered to a full queue
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      job_push |-> !q_status.full)
      else $error("job pushed into full queue");

   // an accepted pixel blocks intake for the following cycle
   a_intake_busy : assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> req_full)
      else $error("intake not blocked after accept");

   // a waiting result is always in range and inside the border
   a_result_range : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_magnitude <= MAG_WIDTH'(MAG_MAX)) && (rsp_out_col != '0)
                     && (rsp_out_row != '0))
      else $error("result out of range");

endmodule
`default_nettype wire
